### design/bfq_pkg.sv
// Shared types, constants and codes for the bounded FIFO queue.
package bfq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = 5;
  localparam int LIMIT_W    = 5;

  localparam logic [CNT_W-1:0]   DEPTH_CNT   = CNT_W'(DEPTH);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(DEPTH);
  localparam logic [PTR_W-1:0]   PTR_LAST    = PTR_W'(DEPTH - 1);

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_DEQUEUE = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef struct packed {
    logic                         command;
    logic signed [DATA_WIDTH-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] data_out;
    logic [1:0]                   status;
    logic [CNT_W-1:0]             element_count;
  } out_item_t;

  // One classified operation handed from the front to the back.
  typedef struct packed {
    op_t                   op;
    logic [PTR_W-1:0]      addr;
    logic [DATA_WIDTH-1:0] data;
    status_t               status;
    logic [CNT_W-1:0]      count;
  } work_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

### design/bfq_front.sv
// Front end: accepts commands, tracks pointers and count, classifies each item.
module bfq_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [bfq_pkg::LIMIT_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bfq_pkg::in_item_t             in_item,
  output logic                          push_valid,
  input  logic                          push_ready,
  output bfq_pkg::work_t                push_work
);
  import bfq_pkg::*;

  logic [LIMIT_W-1:0] limit;
  logic [PTR_W-1:0]   head, head_next;
  logic [PTR_W-1:0]   tail, tail_next;
  logic [CNT_W-1:0]   occupancy, occupancy_next;
  logic [CNT_W-1:0]   eff_limit;
  logic               accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign eff_limit  = (limit > LIMIT_W'(DEPTH)) ? DEPTH_CNT : CNT_W'(limit);

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    occupancy_next = occupancy;
    push_work.op     = OP_NONE;
    push_work.addr   = head;
    push_work.data   = in_item.data_in;
    push_work.status = STATUS_OK;
    if (in_item.command == CMD_ENQUEUE) begin
      if (occupancy >= eff_limit) begin
        push_work.status = STATUS_OVERFLOW;
      end else begin
        push_work.op   = OP_WRITE;
        push_work.addr = tail;
        tail_next      = next_slot(tail);
        occupancy_next = occupancy + CNT_W'(1);
      end
    end else begin
      if (occupancy == '0) begin
        push_work.status = STATUS_UNDERFLOW;
      end else begin
        push_work.op   = OP_READ;
        head_next      = next_slot(head);
        occupancy_next = occupancy - CNT_W'(1);
      end
    end
    push_work.count = occupancy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= LIMIT_RESET;
      head      <= '0;
      tail      <= '0;
      occupancy <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit <= cfg_wr_data;
      end
      if (accept) begin
        head      <= head_next;
        tail      <= tail_next;
        occupancy <= occupancy_next;
      end
    end
  end

endmodule

### design/bfq_work_queue.sv
// Two-entry queue of classified operations between front and back.
module bfq_work_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  bfq_pkg::work_t  push_work,
  output logic            pop_valid,
  input  logic            pop_ready,
  output bfq_pkg::work_t  pop_work
);
  import bfq_pkg::*;

  work_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_work   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_work;
    end
  end

endmodule

### design/bfq_back.sv
// Back end: carries out writes and reads on the entry store, holds the result.
module bfq_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               work_valid,
  output logic               work_ready,
  input  bfq_pkg::work_t     work,
  output logic               out_valid,
  input  logic               out_ready,
  output bfq_pkg::out_item_t out_item
);
  import bfq_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata;
  logic                  res_valid;
  logic                  res_read;
  status_t               res_status;
  logic [CNT_W-1:0]      res_count;
  logic                  take;

  assign work_ready = !res_valid || out_ready;
  assign take       = work_valid && work_ready;

  assign out_valid              = res_valid;
  assign out_item.data_out      = res_read ? rdata : '0;
  assign out_item.status        = res_status;
  assign out_item.element_count = res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_read   <= (work.op == OP_READ);
      res_status <= work.status;
      res_count  <= work.count;
    end
  end

  // Entry store: one write or one registered read per operation.
  always_ff @(posedge clk) begin
    if (take && work.op == OP_WRITE) begin
      mem[work.addr] <= work.data;
    end
    if (take && work.op == OP_READ) begin
      rdata <= mem[work.addr];
    end
  end

endmodule

### design/bounded_fifo_queue_top.sv
// Top level of the bounded FIFO queue: front end, work queue and back end.
//
// Usage:
//   Input channel (in_valid / in_ready / in_item) takes one command per item:
//   enqueue of data_in, or dequeue. Output channel (out_valid / out_ready /
//   out_item) returns exactly one result per command, in command order, with
//   the dequeued word (zero otherwise), a status code and the element count.
//   cfg_wr_en / cfg_wr_data set the capacity limit; write it only while idle.
//   A command's operation is registered in the work queue, then its result in
//   the back end's result register, which drives the output.
//   Throughput: one item per cycle unless out_ready stalls, set by the
//   back end, which does one write or one read per cycle.
//   The front end updates pointers and count at accept time, so it never waits
//   on the store; the two-entry work queue decouples it from the back end.
//   Reset: the queue empties, pointers go to slot zero, the limit returns to
//   the full depth. Entry contents are not cleared; only written slots are read.
//   Receiver stall: the held result stays put, the back end stops, the work
//   queue fills, and in_ready drops once both queue slots are taken.
module bounded_fifo_queue_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [bfq_pkg::LIMIT_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bfq_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bfq_pkg::out_item_t          out_item
);
  import bfq_pkg::*;

  // Front to queue.
  logic  push_valid;
  logic  push_ready;
  work_t push_work;

  // Queue to back.
  logic  work_valid;
  logic  work_ready;
  work_t work;

  // Classify commands and advance pointers at accept.
  bfq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_work   (push_work)
  );

  // Hold classified operations while the back end stalls.
  bfq_work_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_work  (push_work),
    .pop_valid  (work_valid),
    .pop_ready  (work_ready),
    .pop_work   (work)
  );

  // Drive the entry store and present results.
  bfq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (work_valid),
    .work_ready (work_ready),
    .work       (work),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

### design/bfq_checker.sv
// Port-level checks for the bounded FIFO queue, bound to the top level.
module bfq_port_checks (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input bfq_pkg::in_item_t           in_item,
  input logic                        out_valid,
  input logic                        out_ready,
  input bfq_pkg::out_item_t          out_item
);
  import bfq_pkg::*;

  // A waiting item holds.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("item changed while waiting");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Failed operations return no data.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == STATUS_OVERFLOW ||
                  out_item.status == STATUS_UNDERFLOW) |-> out_item.data_out == '0)
    else $error("failed operation returned data");

  // Underflow only on an empty queue.
  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == STATUS_UNDERFLOW |-> out_item.element_count == '0)
    else $error("underflow with nonzero count");

  // Count never exceeds the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.element_count <= DEPTH_CNT)
    else $error("element count above depth");

endmodule

bind bounded_fifo_queue_top bfq_port_checks u_bfq_port_checks (.*);
